[design/vli_pkg.sv]
// ----------------------------------------------------------------------------
// vli_pkg
// Shared types and constants for the three-axis linear interpolator.
// ----------------------------------------------------------------------------
package vli_pkg;

	localparam int AXES      = 3;
	localparam int SAMPLE_W  = 16;
	localparam int TIME_W    = 32;
	localparam int DIV_W     = TIME_W + 1;
	localparam int NUM_W     = DIV_W + SAMPLE_W;
	localparam int CELLS     = SAMPLE_W;

	typedef logic [AXES-1:0][DIV_W:0]      rem_t;
	typedef logic [AXES-1:0][SAMPLE_W-1:0] quo_t;

	typedef struct packed {
		logic              vld;
		logic              err;
		logic [TIME_W-1:0] tq;
		logic [DIV_W-1:0]  dv;
		logic [AXES-1:0]   neg;
		rem_t              rem;
		quo_t              num;
	} div_stage_t;

endpackage

[design/vli_front.sv]
// ----------------------------------------------------------------------------
// vli_front
// Time distances, weighted sums and rounding bias ahead of the divider chain.
// ----------------------------------------------------------------------------
module vli_front
	import vli_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            short_ts,
	input  logic                            in_vld,
	input  logic [AXES-1:0][SAMPLE_W-1:0]   a_in,
	input  logic [AXES-1:0][SAMPLE_W-1:0]   b_in,
	input  logic [TIME_W-1:0]               t0_in,
	input  logic [TIME_W-1:0]               t1_in,
	input  logic [TIME_W-1:0]               tq_in,
	output div_stage_t                      st_o
);

	logic [TIME_W-1:0] d0_raw, d1_raw;

	logic                          vld_s1, vld_s2, vld_s3;
	logic [TIME_W-1:0]             d0_s1, d1_s1, tq_s1, tq_s2, tq_s3;
	logic [AXES-1:0][SAMPLE_W-1:0] a_s1, b_s1;
	logic [DIV_W-1:0]              dt_s2, dt_s3;
	logic signed [NUM_W-1:0]       p0_s2 [AXES];
	logic signed [NUM_W-1:0]       p1_s2 [AXES];
	logic signed [NUM_W:0]         sum_s3 [AXES];

	assign d0_raw = tq_in - t0_in;
	assign d1_raw = t1_in - tq_in;

	always_ff @(posedge clk) begin
		d0_s1 <= short_ts ? {16'd0, d0_raw[15:0]} : d0_raw;
		d1_s1 <= short_ts ? {16'd0, d1_raw[15:0]} : d1_raw;
		a_s1  <= a_in;
		b_s1  <= b_in;
		tq_s1 <= tq_in;
		tq_s2 <= tq_s1;
		tq_s3 <= tq_s2;
		dt_s2 <= {1'b0, d0_s1} + {1'b0, d1_s1};
		dt_s3 <= dt_s2;
		for (int i = 0; i < AXES; i++) begin
			p0_s2[i]  <= $signed({1'b0, d1_s1}) * $signed(a_s1[i]);
			p1_s2[i]  <= $signed({1'b0, d0_s1}) * $signed(b_s1[i]);
			sum_s3[i] <= {p0_s2[i][NUM_W-1], p0_s2[i]} + {p1_s2[i][NUM_W-1], p1_s2[i]};
		end
	end

	logic [NUM_W-1:0] mag [AXES];
	logic [NUM_W-1:0] biased [AXES];

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			mag[i]    = sum_s3[i][NUM_W] ? NUM_W'(-sum_s3[i]) : NUM_W'(sum_s3[i]);
			biased[i] = mag[i] + NUM_W'(dt_s3 >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			st_o   <= '0;
		end else begin
			vld_s1   <= in_vld;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			st_o.vld <= vld_s3;
			st_o.err <= (dt_s3 == '0);
			st_o.tq  <= tq_s3;
			st_o.dv  <= dt_s3;
			for (int i = 0; i < AXES; i++) begin
				st_o.neg[i] <= sum_s3[i][NUM_W];
				st_o.rem[i] <= {1'b0, biased[i][NUM_W-1:SAMPLE_W]};
				st_o.num[i] <= biased[i][SAMPLE_W-1:0];
			end
		end
	end

endmodule

[design/vli_cell.sv]
// ----------------------------------------------------------------------------
// vli_cell
// One restoring division step for all three axes; shifts one quotient bit in.
// ----------------------------------------------------------------------------
module vli_cell
	import vli_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  div_stage_t st_i,
	output div_stage_t st_o
);

	logic [DIV_W:0] trial [AXES];
	logic [AXES-1:0] fits;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			trial[i] = {st_i.rem[i][DIV_W-1:0], st_i.num[i][SAMPLE_W-1]};
			fits[i]  = (trial[i] >= {1'b0, st_i.dv});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_o <= '0;
		end else begin
			st_o.vld <= st_i.vld;
			st_o.err <= st_i.err;
			st_o.tq  <= st_i.tq;
			st_o.dv  <= st_i.dv;
			st_o.neg <= st_i.neg;
			for (int i = 0; i < AXES; i++) begin
				st_o.rem[i] <= fits[i] ? trial[i] - {1'b0, st_i.dv} : trial[i];
				st_o.num[i] <= {st_i.num[i][SAMPLE_W-2:0], fits[i]};
			end
		end
	end

endmodule

[design/vec3_int16_linear_interp.sv]
// ----------------------------------------------------------------------------
// vec3_int16_linear_interp
// Three-axis rounded linear interpolation between two timestamped samples.
// ----------------------------------------------------------------------------
// Pipeline: 4 front stages, 16 divider cells and one output register lie
// between start and done.
// Throughput: one item per cycle; busy is never raised, the row of divider
// cells retires one quotient bit per cell per cycle; done cannot be held off.
// Reset clears short_timestamps, valid flags and stage outputs; no clearing pass.
module vec3_int16_linear_interp
	import vli_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [15:0]         first_x,
	input  logic signed [15:0]         first_y,
	input  logic signed [15:0]         first_z,
	input  logic signed [15:0]         second_x,
	input  logic signed [15:0]         second_y,
	input  logic signed [15:0]         second_z,
	input  logic [31:0]                first_time,
	input  logic [31:0]                second_time,
	input  logic [31:0]                query_time,
	output logic                       done,
	output logic signed [15:0]         out_x,
	output logic signed [15:0]         out_y,
	output logic signed [15:0]         out_z,
	output logic [31:0]                out_time,
	output logic                       interval_error
);

	logic       short_q;
	div_stage_t chain [CELLS+1];
	logic [AXES-1:0][SAMPLE_W-1:0] res;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign prdata = (paddr[2] == 1'b0) ? {31'd0, short_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			short_q <= pwdata[0];
		end
	end

	vli_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.short_ts (short_q),
		.in_vld   (start && !busy),
		.a_in     ({first_z, first_y, first_x}),
		.b_in     ({second_z, second_y, second_x}),
		.t0_in    (first_time),
		.t1_in    (second_time),
		.tq_in    (query_time),
		.st_o     (chain[0])
	);

	for (genvar g = 0; g < CELLS; g++) begin : g_cell
		vli_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.st_i   (chain[g]),
			.st_o   (chain[g+1])
		);
	end

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			if (chain[CELLS].err) begin
				res[i] = '0;
			end else if (chain[CELLS].neg[i]) begin
				res[i] = SAMPLE_W'(-chain[CELLS].num[i]);
			end else begin
				res[i] = chain[CELLS].num[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= chain[CELLS].vld;
		end
	end

	always_ff @(posedge clk) begin
		out_x          <= res[0];
		out_y          <= res[1];
		out_z          <= res[2];
		out_time       <= chain[CELLS].tq;
		interval_error <= chain[CELLS].err;
	end

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(chain[CELLS].vld))
		else $error("done without a finished item");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && interval_error) |-> (out_x == 0 && out_y == 0 && out_z == 0))
		else $error("nonzero axes on interval error");

	a_front_err: assert property (@(posedge clk) disable iff (!arst_n)
		chain[0].vld |-> (chain[0].err == (chain[0].dv == '0)))
		else $error("error flag disagrees with divisor");

endmodule
